@@ sv/htw_pkg.sv @@
package htw_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_TIMERS_DEF = 64;
   localparam int NUM_SLOTS_DEF  = 64;

   // Fixed field widths
   localparam int MS_W     = 24;
   localparam int TAG_W    = 16;
   localparam int HANDLE_W = 6;
   localparam int TICKMS_W = 16;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [TICKMS_W-1:0] TICK_MS_RST = 16'd10;
   localparam logic [CSR_AW-1:0]   ADDR_TICK_MS = 3'd0;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_DEL  = 2'd1,
      OP_TICK = 2'd2,
      OP_NOP  = 2'd3
   } op_type;

   localparam logic [1:0] KIND_ADD  = 2'd0;
   localparam logic [1:0] KIND_DEL  = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   // Command passed from the front part to the back part
   typedef struct packed {
      op_type              op;
      logic [MS_W-1:0]     interval_ms;
      logic                recurring;
      logic [TAG_W-1:0]    tag;
      logic [HANDLE_W-1:0] handle_in;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_FULL,
      ST_ADD_DIV1,
      ST_ADD_DIV2,
      ST_ADD_WR,
      ST_DEL,
      ST_TK_RD,
      ST_TK_EV,
      ST_TK_END
   } state_type;

endpackage

@@ sv/htw_req_if.sv @@
interface htw_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        op;
   logic [htw_pkg::MS_W-1:0]          interval_ms;
   logic                              recurring;
   logic [htw_pkg::TAG_W-1:0]         tag;
   logic [htw_pkg::HANDLE_W-1:0]      handle_in;

   modport source (output valid, op, interval_ms, recurring, tag, handle_in, input ready);
   modport sink (input valid, op, interval_ms, recurring, tag, handle_in, output ready);
endinterface

@@ sv/htw_rsp_if.sv @@
interface htw_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        kind;
   logic [htw_pkg::HANDLE_W-1:0]      handle_out;
   logic [htw_pkg::TAG_W-1:0]         expired_tag;
   logic                              fired;
   logic                              ok;
   logic                              last;

   modport source (output valid, kind, handle_out, expired_tag, fired, ok, last, input ready);
   modport sink (input valid, kind, handle_out, expired_tag, fired, ok, last, output ready);
endinterface

@@ sv/htw_ram.sv @@
module htw_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                              rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ sv/htw_div.sv @@
module htw_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [htw_pkg::MS_W-1:0]          dividend,
   input  logic [htw_pkg::TICKMS_W-1:0]      divisor,
   output logic                              done,
   output logic [htw_pkg::MS_W-1:0]          quotient
);
   localparam int CntW = $clog2(htw_pkg::MS_W + 1);

   logic [CntW-1:0]                cnt_ff, cnt_in;
   logic                           done_ff, done_in;
   logic [htw_pkg::MS_W-1:0]       quo_ff, quo_in;
   logic [htw_pkg::TICKMS_W-1:0]   rem_ff, rem_in;
   logic [htw_pkg::TICKMS_W-1:0]   dvs_ff, dvs_in;
   logic [htw_pkg::TICKMS_W:0]     trial;

   // One quotient bit per cycle, restoring
   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[htw_pkg::MS_W-1]};
      if (start) begin
         cnt_in = CntW'(htw_pkg::MS_W);
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = htw_pkg::TICKMS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[htw_pkg::MS_W-2:0], 1'b1};
         end else begin
            rem_in = trial[htw_pkg::TICKMS_W-1:0];
            quo_in = {quo_ff[htw_pkg::MS_W-2:0], 1'b0};
         end
         done_in = (cnt_ff == CntW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
endmodule

@@ sv/htw_front.sv @@
module htw_front (
   input  logic                clock,
   input  logic                reset,
   htw_req_if.sink             req,
   output logic                cmd_vld,
   output htw_pkg::cmd_type    cmd,
   input  logic                cmd_pop
);
   htw_pkg::cmd_type fifo_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       cnt_ff;
   logic             accept, push;
   htw_pkg::cmd_type word;

   // Accept a word whenever the queue has room; drop unused op codes
   assign req.ready = (cnt_ff != 2'd2);
   assign accept    = req.valid && req.ready;
   assign push      = accept && (htw_pkg::op_type'(req.op) != htw_pkg::OP_NOP);

   always_comb begin
      word.op          = htw_pkg::op_type'(req.op);
      word.interval_ms = req.interval_ms;
      word.recurring   = req.recurring;
      word.tag         = req.tag;
      word.handle_in   = req.handle_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, cmd_pop};
      end
      if (push) begin
         fifo_ff[wr_ptr_ff] <= word;
      end
   end

   assign cmd_vld = (cnt_ff != 2'd0);
   assign cmd     = fifo_ff[rd_ptr_ff];
endmodule

@@ sv/htw_back.sv @@
module htw_back #(
   parameter int MaxTimers = htw_pkg::MAX_TIMERS_DEF,
   parameter int NumSlots  = htw_pkg::NUM_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_vld,
   input  htw_pkg::cmd_type                cmd,
   output logic                            cmd_pop,
   input  logic [htw_pkg::TICKMS_W-1:0]    tick_ms,
   htw_rsp_if.source                       rsp
);
   localparam int HW    = (MaxTimers > 1) ? $clog2(MaxTimers) : 1;
   localparam int SlotW = $clog2(NumSlots);
   localparam int RndW  = htw_pkg::MS_W - ($clog2(NumSlots + 1) - 1);
   // Reciprocal of the slot count, exact for every dividend below 2**MS_W
   localparam int RecL  = $clog2(NumSlots);
   localparam int RecW  = htw_pkg::MS_W + 1;
   localparam int PrdW  = htw_pkg::MS_W + RecW;
   localparam longint unsigned RecipFull =
      ((64'd1 << (htw_pkg::MS_W + RecL)) / NumSlots) + 1;
   localparam logic [RecW-1:0] Recip = RecW'(RecipFull);

   typedef struct packed {
      logic [SlotW-1:0]          slot;
      logic [RndW-1:0]           rounds;
      logic [RndW-1:0]           iq;
      logic [SlotW-1:0]          ir;
      logic                      rpt;
      logic [htw_pkg::TAG_W-1:0] tag;
   } ent_type;

   htw_pkg::state_type state_ff, state_in;
   htw_pkg::cmd_type   cmd_ff, cmd_in;
   logic [SlotW-1:0]   cur_ff, cur_in;
   logic               valid_ff [MaxTimers];
   logic               valid_in [MaxTimers];
   logic [HW-1:0]      e_ff, e_in;
   logic [HW-1:0]      free_ff, free_in;
   logic               pend_vld_ff, pend_vld_in;
   logic [HW-1:0]      pend_h_ff, pend_h_in;
   logic [htw_pkg::TAG_W-1:0] pend_tag_ff, pend_tag_in;
   logic [RndW-1:0]    rnd_ff, rnd_in;

   logic               out_vld_ff, out_vld_in;
   logic [1:0]         kind_ff, kind_in;
   logic [htw_pkg::HANDLE_W-1:0] hout_ff, hout_in;
   logic [htw_pkg::TAG_W-1:0]    etag_ff, etag_in;
   logic               fired_ff, fired_in;
   logic               ok_ff, ok_in;
   logic               last_ff, last_in;

   logic               out_free, full, emit;
   logic [HW-1:0]      free_idx;
   logic               div_start, div_done;
   logic [htw_pkg::MS_W-1:0]     div_a, div_q;
   logic [htw_pkg::TICKMS_W-1:0] div_b;
   logic [PrdW-1:0]    prod;
   logic [SlotW-1:0]   add_r;
   logic               wr_en, rd_en;
   logic [HW-1:0]      wr_addr;
   ent_type            wr_data, rd_data;
   logic               del_hit, hit, expire, step_ok, last_e;
   logic [SlotW:0]     arm_sum;
   logic [SlotW-1:0]   arm_slot, arm_r;

   assign out_free = !out_vld_ff || rsp.ready;

   // Lowest free entry
   always_comb begin
      free_idx = '0;
      full     = 1'b1;
      for (int i = MaxTimers - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = HW'(i);
            full     = 1'b0;
         end
      end
   end

   assign del_hit = ({1'b0, cmd_ff.handle_in} < (htw_pkg::HANDLE_W + 1)'(MaxTimers))
                    && valid_ff[cmd_ff.handle_in[HW-1:0]];
   assign hit     = valid_ff[e_ff] && (rd_data.slot == cur_ff);
   assign expire  = hit && (rd_data.rounds == '0);
   assign step_ok = !expire || !pend_vld_ff || out_free;
   assign last_e  = (e_ff == HW'(MaxTimers - 1));

   // Split ticks into rounds (reciprocal multiply) and slot offset
   assign prod  = {{RecW{1'b0}}, div_q} * {{htw_pkg::MS_W{1'b0}}, Recip};
   assign add_r = div_q[SlotW-1:0] - SlotW'(rnd_ff * NumSlots);

   // Slot arming: current slot plus offset, wrapped once
   assign arm_r    = (state_ff == htw_pkg::ST_TK_EV) ? rd_data.ir : add_r;
   assign arm_sum  = {1'b0, cur_ff} + {1'b0, arm_r};
   assign arm_slot = (arm_sum >= (SlotW + 1)'(NumSlots))
                     ? SlotW'(arm_sum - (SlotW + 1)'(NumSlots)) : arm_sum[SlotW-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         htw_pkg::ST_IDLE: begin
            if (cmd_vld) begin
               unique case (cmd.op)
                  htw_pkg::OP_ADD:  state_in = full ? htw_pkg::ST_ADD_FULL
                                                    : htw_pkg::ST_ADD_DIV1;
                  htw_pkg::OP_DEL:  state_in = htw_pkg::ST_DEL;
                  htw_pkg::OP_TICK: state_in = htw_pkg::ST_TK_RD;
                  default:          state_in = htw_pkg::ST_IDLE;
               endcase
            end
         end
         htw_pkg::ST_ADD_DIV1: if (div_done) state_in = htw_pkg::ST_ADD_DIV2;
         htw_pkg::ST_ADD_DIV2: state_in = htw_pkg::ST_ADD_WR;
         htw_pkg::ST_ADD_FULL, htw_pkg::ST_ADD_WR, htw_pkg::ST_DEL: begin
            if (out_free) state_in = htw_pkg::ST_IDLE;
         end
         htw_pkg::ST_TK_RD: state_in = htw_pkg::ST_TK_EV;
         htw_pkg::ST_TK_EV: begin
            if (step_ok) state_in = last_e ? htw_pkg::ST_TK_END : htw_pkg::ST_TK_RD;
         end
         htw_pkg::ST_TK_END: if (out_free) state_in = htw_pkg::ST_IDLE;
         default: state_in = htw_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      cmd_in      = cmd_ff;
      cur_in      = cur_ff;
      valid_in    = valid_ff;
      e_in        = e_ff;
      free_in     = free_ff;
      pend_vld_in = pend_vld_ff;
      pend_h_in   = pend_h_ff;
      pend_tag_in = pend_tag_ff;
      rnd_in      = rnd_ff;
      cmd_pop     = 1'b0;
      div_start   = 1'b0;
      div_a       = cmd.interval_ms;
      div_b       = (tick_ms == '0) ? htw_pkg::TICKMS_W'(1) : tick_ms;
      wr_en       = 1'b0;
      wr_addr     = e_ff;
      wr_data     = rd_data;
      rd_en       = 1'b0;
      emit        = 1'b0;
      kind_in     = htw_pkg::KIND_TICK;
      hout_in     = '0;
      etag_in     = '0;
      fired_in    = 1'b0;
      ok_in       = 1'b0;
      last_in     = 1'b1;
      unique case (state_ff)
         htw_pkg::ST_IDLE: begin
            if (cmd_vld) begin
               cmd_pop     = 1'b1;
               cmd_in      = cmd;
               free_in     = free_idx;
               e_in        = '0;
               pend_vld_in = 1'b0;
               div_start   = (cmd.op == htw_pkg::OP_ADD) && !full;
            end
         end
         htw_pkg::ST_ADD_DIV1: ;
         htw_pkg::ST_ADD_DIV2: begin
            rnd_in = prod[htw_pkg::MS_W + RecL +: RndW];
         end
         htw_pkg::ST_ADD_FULL: begin
            emit    = out_free;
            kind_in = htw_pkg::KIND_ADD;
         end
         htw_pkg::ST_ADD_WR: begin
            emit    = out_free;
            kind_in = htw_pkg::KIND_ADD;
            hout_in = htw_pkg::HANDLE_W'(free_ff);
            ok_in   = 1'b1;
            if (out_free) begin
               wr_en          = 1'b1;
               wr_addr        = free_ff;
               wr_data.slot   = arm_slot;
               wr_data.rounds = rnd_ff;
               wr_data.iq     = rnd_ff;
               wr_data.ir     = add_r;
               wr_data.rpt    = cmd_ff.recurring;
               wr_data.tag    = cmd_ff.tag;
               valid_in[free_ff] = 1'b1;
            end
         end
         htw_pkg::ST_DEL: begin
            emit    = out_free;
            kind_in = htw_pkg::KIND_DEL;
            hout_in = cmd_ff.handle_in;
            ok_in   = del_hit;
            if (out_free && del_hit) begin
               valid_in[cmd_ff.handle_in[HW-1:0]] = 1'b0;
            end
         end
         htw_pkg::ST_TK_RD: rd_en = 1'b1;
         htw_pkg::ST_TK_EV: begin
            if (step_ok) begin
               if (!last_e) e_in = e_ff + 1'b1;
               if (hit && !expire) begin
                  wr_en          = 1'b1;
                  wr_data.rounds = rd_data.rounds - 1'b1;
               end
               if (expire) begin
                  // Release the held report, hold this one
                  emit        = pend_vld_ff;
                  hout_in     = htw_pkg::HANDLE_W'(pend_h_ff);
                  etag_in     = pend_tag_ff;
                  fired_in    = 1'b1;
                  last_in     = 1'b0;
                  pend_vld_in = 1'b1;
                  pend_h_in   = e_ff;
                  pend_tag_in = rd_data.tag;
                  if (rd_data.rpt) begin
                     wr_en          = 1'b1;
                     wr_data.slot   = arm_slot;
                     wr_data.rounds = rd_data.iq;
                  end else begin
                     valid_in[e_ff] = 1'b0;
                  end
               end
            end
         end
         htw_pkg::ST_TK_END: begin
            emit = out_free;
            if (pend_vld_ff) begin
               hout_in  = htw_pkg::HANDLE_W'(pend_h_ff);
               etag_in  = pend_tag_ff;
               fired_in = 1'b1;
            end
            if (out_free) begin
               cur_in = (cur_ff == SlotW'(NumSlots - 1)) ? '0 : cur_ff + 1'b1;
            end
         end
         default: ;
      endcase
      out_vld_in = emit || (out_vld_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= htw_pkg::ST_IDLE;
         cur_ff      <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         for (int i = 0; i < MaxTimers; i++) valid_ff[i] <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cur_ff      <= cur_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
         valid_ff    <= valid_in;
      end
      cmd_ff      <= cmd_in;
      e_ff        <= e_in;
      free_ff     <= free_in;
      pend_h_ff   <= pend_h_in;
      pend_tag_ff <= pend_tag_in;
      rnd_ff      <= rnd_in;
      if (emit) begin
         kind_ff  <= kind_in;
         hout_ff  <= hout_in;
         etag_ff  <= etag_in;
         fired_ff <= fired_in;
         ok_ff    <= ok_in;
         last_ff  <= last_in;
      end
   end

   htw_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_q)
   );

   htw_ram #(.Width($bits(ent_type)), .Depth(MaxTimers)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (e_ff),
      .rd_data (rd_data)
   );

   assign rsp.valid       = out_vld_ff;
   assign rsp.kind        = kind_ff;
   assign rsp.handle_out  = hout_ff;
   assign rsp.expired_tag = etag_ff;
   assign rsp.fired       = fired_ff;
   assign rsp.ok          = ok_ff;
   assign rsp.last        = last_ff;
endmodule

@@ sv/hashed_timing_wheel.sv @@
// Timer table on a hashed timing wheel.
// req channel: one word per operation (add, delete, tick); op code 3 is
// taken and dropped. rsp channel: add and delete give one word each, a tick
// gives one word per expired timer in entry order, or one word with
// fired=0 when nothing expires; the final word of an operation has last=1.
// Words are queued two deep in the front part, so req can take up to two
// words while the back part works or rsp stalls.
// An add waits on the bit-serial divider (ticks = interval/tick_ms),
// then on a reciprocal multiply splitting ticks into rounds and slot;
// a tick walks the entry memory one entry at a time, reading each entry
// and writing it back where it is due, before it gives its last word.
// When rsp stalls, the back part holds and the req queue fills up.
// Reset empties the table, sets the slot to 0 and tick_ms to 10; no
// clearing pass is needed. tick_ms is written over the csr port
// (address 0); the user must write it only while the block is idle,
// which the block itself does not enforce; 0 counts as 1.
module hashed_timing_wheel #(
   parameter int MAX_TIMERS = htw_pkg::MAX_TIMERS_DEF,
   parameter int NUM_SLOTS  = htw_pkg::NUM_SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   htw_req_if.sink                       req,
   htw_rsp_if.source                     rsp,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [htw_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [htw_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [htw_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   logic [htw_pkg::TICKMS_W-1:0] tick_ms_ff;
   logic                         cmd_vld, cmd_pop;
   htw_pkg::cmd_type             cmd;

   // Register write and read
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ms_ff <= htw_pkg::TICK_MS_RST;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr == htw_pkg::ADDR_TICK_MS)) begin
         tick_ms_ff <= csr_pwdata[htw_pkg::TICKMS_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == htw_pkg::ADDR_TICK_MS)
                       ? htw_pkg::CSR_DW'(tick_ms_ff) : '0;

   htw_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .cmd_vld (cmd_vld),
      .cmd     (cmd),
      .cmd_pop (cmd_pop)
   );

   htw_back #(.MaxTimers(MAX_TIMERS), .NumSlots(NUM_SLOTS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .cmd_vld (cmd_vld),
      .cmd     (cmd),
      .cmd_pop (cmd_pop),
      .tick_ms (tick_ms_ff),
      .rsp     (rsp)
   );
endmodule
